[rtl/tcm_pkg.sv]
// Shared widths, fixed-point formats and Turbo polynomial coefficients.
package tcm_pkg;

    localparam int LEVEL_W             = 16;
    localparam int LEVEL_FRACTION_BITS = 15;
    localparam int ACC_FRAC            = 24;
    localparam int LEVEL_SHIFT         = ACC_FRAC - LEVEL_FRACTION_BITS;
    localparam int LEVEL_ONE           = 1 << LEVEL_FRACTION_BITS;

    // t is in [0, 1.0] with ACC_FRAC fraction bits
    localparam int T_W     = ACC_FRAC + 1;
    // Horner partial sums stay inside +/-256 for t in [0, 1]
    localparam int ACC_W   = ACC_FRAC + 10;
    localparam int PROD_W  = ACC_W + T_W + 1;
    localparam int PIX_W   = 8;
    localparam int SCALE_W = T_W + PIX_W;

    localparam int NUM_CH    = 3;
    localparam int NUM_COEF  = 6;
    localparam int NUM_STEP  = NUM_COEF - 1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [T_W-1:0]          t_t;
    typedef logic [PIX_W-1:0]        pix_t;

    localparam acc_t ACC_ONE = acc_t'(64'sd1 <<< ACC_FRAC);

    // 8-decimal coefficients scaled by 2^24, rounded half up on the magnitude
    localparam longint Q_ONE  = 64'sd16777216;
    localparam longint Q_HALF = 64'sd50000000;
    localparam longint Q_DIV  = 64'sd100000000;

    // COEF[channel][k] is c_k
    localparam acc_t COEF [NUM_CH][NUM_COEF] = '{
        '{
            acc_t'(  (64'sd13572138    * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(  (64'sd461539260   * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(-((64'sd4266032258  * Q_ONE + Q_HALF) / Q_DIV)),
            acc_t'(  (64'sd13213108234 * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(-((64'sd15294239396 * Q_ONE + Q_HALF) / Q_DIV)),
            acc_t'(  (64'sd5928637943  * Q_ONE + Q_HALF) / Q_DIV)
        },
        '{
            acc_t'(  (64'sd9140261     * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(  (64'sd219418839   * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(  (64'sd484296658   * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(-((64'sd1418503333  * Q_ONE + Q_HALF) / Q_DIV)),
            acc_t'(  (64'sd427729857   * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(  (64'sd282956604   * Q_ONE + Q_HALF) / Q_DIV)
        },
        '{
            acc_t'(  (64'sd10667330    * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(  (64'sd1264194608  * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(-((64'sd6058204836  * Q_ONE + Q_HALF) / Q_DIV)),
            acc_t'(  (64'sd11036276771 * Q_ONE + Q_HALF) / Q_DIV),
            acc_t'(-((64'sd8990310912  * Q_ONE + Q_HALF) / Q_DIV)),
            acc_t'(  (64'sd2734824973  * Q_ONE + Q_HALF) / Q_DIV)
        }
    };

endpackage

[rtl/turbo_colormap_lookup.sv]
// Turbo false-colour lookup: level to RGB through a pipelined Horner evaluation.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   request  | s_valid s_ready s_level[15:0]      | in
//   result   | m_valid m_ready m_red m_green m_blue | out
//
// Seven register stages: saturate/scale level, five Horner steps (three
// channel multipliers each), clamp and scale by 255. One request per cycle
// sustained while m_ready is high. Each stage holds its own valid bit and
// loads when it is empty or its successor moves, so bubbles close up and a
// stall on m_ready loses nothing. Reset clears only the valid bits.
module turbo_colormap_lookup (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tcm_pkg::LEVEL_W-1:0] s_level,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcm_pkg::pix_t               m_red,
    output tcm_pkg::pix_t               m_green,
    output tcm_pkg::pix_t               m_blue
);

    localparam int NUM_STAGE = tcm_pkg::NUM_STEP + 2;

    logic [NUM_STAGE-1:0] valid_reg;
    logic [NUM_STAGE-1:0] in_valid;
    logic [NUM_STAGE:0]   ready;

    tcm_pkg::t_t   t_next;
    tcm_pkg::t_t   t_reg   [tcm_pkg::NUM_STEP];
    tcm_pkg::acc_t acc_next [tcm_pkg::NUM_STEP][tcm_pkg::NUM_CH];
    tcm_pkg::acc_t acc_reg  [tcm_pkg::NUM_STEP][tcm_pkg::NUM_CH];
    tcm_pkg::pix_t pix_next [tcm_pkg::NUM_CH];
    tcm_pkg::pix_t pix_reg  [tcm_pkg::NUM_CH];

    // ---- flow control
    assign in_valid = {valid_reg[NUM_STAGE-2:0], s_valid};
    assign ready[NUM_STAGE] = m_ready;

    for (genvar k = 0; k < NUM_STAGE; k++) begin : g_ready
        assign ready[k] = !valid_reg[k] || ready[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGE; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= in_valid[k];
                end
            end
        end
    end

    assign s_ready = ready[0];
    assign m_valid = valid_reg[NUM_STAGE-1];

    // ---- stage 0: saturate level to 1.0 and move to 24 fraction bits
    always_comb begin
        if (tcm_pkg::T_W'(s_level) > tcm_pkg::T_W'(tcm_pkg::LEVEL_ONE)) begin
            t_next = tcm_pkg::T_W'(tcm_pkg::LEVEL_ONE) << tcm_pkg::LEVEL_SHIFT;
        end else begin
            t_next = tcm_pkg::T_W'(s_level) << tcm_pkg::LEVEL_SHIFT;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[0] && in_valid[0]) begin
            t_reg[0] <= t_next;
        end
        for (int j = 1; j < tcm_pkg::NUM_STEP; j++) begin
            if (ready[j] && in_valid[j]) begin
                t_reg[j] <= t_reg[j-1];
            end
        end
    end

    // ---- stages 1..5: Horner steps, starting from c5
    for (genvar j = 0; j < tcm_pkg::NUM_STEP; j++) begin : g_step
        for (genvar ch = 0; ch < tcm_pkg::NUM_CH; ch++) begin : g_ch
            tcm_pkg::acc_t acc_src;

            if (j == 0) begin : g_first
                assign acc_src = tcm_pkg::COEF[ch][tcm_pkg::NUM_COEF-1];
            end else begin : g_rest
                assign acc_src = acc_reg[j-1][ch];
            end

            tcm_horner_step u_step (
                .acc_in  (acc_src),
                .t_in    (t_reg[j]),
                .coef    (tcm_pkg::COEF[ch][tcm_pkg::NUM_STEP-1-j]),
                .acc_out (acc_next[j][ch])
            );

            always_ff @(posedge aclk) begin
                if (ready[j+1] && in_valid[j+1]) begin
                    acc_reg[j][ch] <= acc_next[j][ch];
                end
            end
        end
    end

    // ---- last stage: clamp to [0,1], times 255, keep the integer part
    for (genvar ch = 0; ch < tcm_pkg::NUM_CH; ch++) begin : g_pix
        tcm_pkg::acc_t                 acc_fin;
        tcm_pkg::t_t                   clamped;
        logic [tcm_pkg::SCALE_W-1:0]   scaled;

        assign acc_fin = acc_reg[tcm_pkg::NUM_STEP-1][ch];

        always_comb begin
            if (acc_fin[tcm_pkg::ACC_W-1]) begin
                clamped = '0;
            end else if (acc_fin > tcm_pkg::ACC_ONE) begin
                clamped = tcm_pkg::T_W'(tcm_pkg::ACC_ONE);
            end else begin
                clamped = acc_fin[tcm_pkg::T_W-1:0];
            end
        end

        assign scaled = (tcm_pkg::SCALE_W'(clamped) << tcm_pkg::PIX_W)
                        - tcm_pkg::SCALE_W'(clamped);
        assign pix_next[ch] = scaled[tcm_pkg::ACC_FRAC +: tcm_pkg::PIX_W];

        always_ff @(posedge aclk) begin
            if (ready[NUM_STAGE-1] && in_valid[NUM_STAGE-1]) begin
                pix_reg[ch] <= pix_next[ch];
            end
        end
    end

    assign m_red   = pix_reg[tcm_pkg::CH_RED];
    assign m_green = pix_reg[tcm_pkg::CH_GREEN];
    assign m_blue  = pix_reg[tcm_pkg::CH_BLUE];

endmodule

[rtl/tcm_horner_step.sv]
// One Horner step for one channel: floor(acc * t / 2^24) + c.
module tcm_horner_step (
    input  tcm_pkg::acc_t acc_in,
    input  tcm_pkg::t_t   t_in,
    input  tcm_pkg::acc_t coef,
    output tcm_pkg::acc_t acc_out
);

    logic signed [tcm_pkg::PROD_W-1:0] prod;

    assign prod = tcm_pkg::PROD_W'(acc_in) * tcm_pkg::PROD_W'($signed({1'b0, t_in}));

    // arithmetic drop of the fraction bits is floor; upper bits are sign copies
    assign acc_out = $signed(prod[tcm_pkg::ACC_FRAC +: tcm_pkg::ACC_W]) + coef;

endmodule
